@@ sv/l2lh_pkg.sv @@
// ----------------------------------------------------------------------------
// l2lh_pkg
// Shared sizes, mode codes, control structs and helper functions for the
// log2 latency histogram.
// ----------------------------------------------------------------------------
package l2lh_pkg;

   localparam int NUM_BUCKETS = 16;
   localparam int BUCKET_W    = $clog2(NUM_BUCKETS);
   localparam int CNT_W       = 32;
   localparam int TOT_W       = CNT_W + BUCKET_W;
   localparam int SUM_W       = 64;
   localparam int US_W        = 32;
   localparam int Q_W         = 17;
   localparam int IDX_W       = 4;
   localparam int UB_W        = 16;
   localparam int MEAN_W      = 32;
   localparam int SAMPLE_W    = 36;
   localparam int PROD_W      = TOT_W + Q_W;
   localparam int DIV_CNT_W   = $clog2(SUM_W);
   localparam int IDX_EXT_W   = (BUCKET_W > IDX_W) ? BUCKET_W : IDX_W;
   localparam int TOT_EXT_W   = (TOT_W > SAMPLE_W) ? TOT_W : SAMPLE_W;

   localparam logic [Q_W-1:0]      Q_ONE      = Q_W'(65536);
   localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = '1;
   localparam logic [BUCKET_W-1:0] LAST_BUCKET = BUCKET_W'(NUM_BUCKETS - 1);

   typedef enum logic [1:0] {
      MODE_RECORD = 2'd0,
      MODE_PCT    = 2'd1,
      MODE_MEAN   = 2'd2,
      MODE_CLEAR  = 2'd3
   } mode_type;

   typedef struct packed {
      logic capture;
      logic record;
      logic clear;
      logic mul;
      logic target;
      logic walk;
      logic div_start;
      logic load_rsp;
   } cmd_type;

   typedef struct packed {
      logic total_zero;
      logic walk_hit;
      logic div_done;
   } status_type;

   // Bucket 0 below 1000 us, else one past the highest 1000*2^j that fits.
   function automatic logic [BUCKET_W-1:0] bucket_of(input logic [US_W-1:0] us);
      logic [BUCKET_W-1:0] b;
      b = '0;
      for (int j = 0; j < NUM_BUCKETS - 1; j++) begin
         if (64'(us) >= (64'd1000 << j)) begin
            b = BUCKET_W'(j + 1);
         end
      end
      return b;
   endfunction

   function automatic logic [UB_W-1:0] bound_ms(input logic [BUCKET_W-1:0] i);
      logic [UB_W-1:0] ub;
      if (i == '0) begin
         ub = UB_W'(1);
      end else if (32'(i) >= 32'd16) begin
         ub = '1;
      end else begin
         ub = UB_W'(1) << i;
      end
      return ub;
   endfunction

   function automatic logic [IDX_W-1:0] idx_out(input logic [BUCKET_W-1:0] b);
      logic [IDX_EXT_W-1:0] e;
      e = IDX_EXT_W'(b);
      return e[IDX_W-1:0];
   endfunction

   function automatic logic [SAMPLE_W-1:0] sat_total(input logic [TOT_W-1:0] t);
      logic [TOT_EXT_W-1:0] e;
      logic [SAMPLE_W-1:0]  r;
      e = TOT_EXT_W'(t);
      if (e > TOT_EXT_W'(SAMPLE_MAX)) begin
         r = SAMPLE_MAX;
      end else begin
         r = e[SAMPLE_W-1:0];
      end
      return r;
   endfunction

endpackage

@@ sv/log2_latency_histogram_core.sv @@
// ----------------------------------------------------------------------------
// log2_latency_histogram_core
// Log2 millisecond latency histogram with percentile and mean queries.
// Request to response: record and clear pass their own state, percentile
// walks the buckets after the target (one bucket per cycle in the walk),
// mean runs the 64-step bit-serial divider, empty queries skip to the response.
// One request in flight; a finished response waits in its own register.
// Synchronous reset clears counters, sum and total at once, no sweep.
// ----------------------------------------------------------------------------
module log2_latency_histogram_core
   import l2lh_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [1:0]          req_mode,
   input  logic [US_W-1:0]     req_latency_us,
   input  logic [Q_W-1:0]      req_quantile_q16,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [IDX_W-1:0]    rsp_bucket_index,
   output logic [UB_W-1:0]     rsp_upper_bound_ms,
   output logic [MEAN_W-1:0]   rsp_mean_us,
   output logic [SAMPLE_W-1:0] rsp_sample_count
);

   cmd_type    cmd;
   status_type stat;

   l2lh_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_mode  (req_mode),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .stat      (stat)
   );

   l2lh_datapath u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .stat               (stat),
      .req_latency_us     (req_latency_us),
      .req_quantile_q16   (req_quantile_q16),
      .rsp_bucket_index   (rsp_bucket_index),
      .rsp_upper_bound_ms (rsp_upper_bound_ms),
      .rsp_mean_us        (rsp_mean_us),
      .rsp_sample_count   (rsp_sample_count)
   );

   // never overwrite a response that is still waiting
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.load_rsp |-> (!rsp_valid || !rsp_stall))
      else $error("response overwritten while stalled");

   a_one_op: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.record, cmd.clear, cmd.mul, cmd.target, cmd.walk,
                cmd.div_start, cmd.load_rsp}))
      else $error("more than one datapath operation at once");

   a_clear_empties: assert property (@(posedge clock) disable iff (reset)
      cmd.clear |=> stat.total_zero)
      else $error("total not zero after clear");

   // hold the response steady while the receiver stalls
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable({rsp_bucket_index,
         rsp_upper_bound_ms, rsp_mean_us, rsp_sample_count})))
      else $error("response changed while stalled");

endmodule

@@ sv/l2lh_divider.sv @@
// ----------------------------------------------------------------------------
// l2lh_divider
// Restoring divider: latency sum over sample total, one quotient bit a cycle.
// ----------------------------------------------------------------------------
module l2lh_divider
   import l2lh_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [SUM_W-1:0] dividend,
   input  logic [TOT_W-1:0] divisor,
   output logic             done,
   output logic [SUM_W-1:0] quotient
);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_CNT_W-1:0] step_ff, step_in;
   logic [TOT_W-1:0]     rem_ff, rem_in;
   logic [SUM_W-1:0]     quo_ff, quo_in;
   logic [TOT_W-1:0]     dvs_ff, dvs_in;
   logic [TOT_W:0]       rem_sh;
   logic [TOT_W:0]       rem_sub;
   logic                 fits;

   always_comb begin
      rem_sh  = {rem_ff, quo_ff[SUM_W-1]};
      rem_sub = rem_sh - {1'b0, dvs_ff};
      fits    = rem_sh >= {1'b0, dvs_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = '0;
         rem_in  = '0;
         quo_in  = dividend;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         // shift the next dividend bit in, take the quotient bit out
         rem_in  = fits ? rem_sub[TOT_W-1:0] : rem_sh[TOT_W-1:0];
         quo_in  = {quo_ff[SUM_W-2:0], fits};
         step_in = step_ff + 1'b1;
         if (step_ff == '1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      step_ff <= step_in;
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      dvs_ff  <= dvs_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

@@ sv/l2lh_datapath.sv @@
// ----------------------------------------------------------------------------
// l2lh_datapath
// Bucket counters, latency sum, percentile walk, mean division and the
// response register.
// ----------------------------------------------------------------------------
module l2lh_datapath
   import l2lh_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  cmd_type             cmd,
   output status_type          stat,
   input  logic [US_W-1:0]     req_latency_us,
   input  logic [Q_W-1:0]      req_quantile_q16,
   output logic [IDX_W-1:0]    rsp_bucket_index,
   output logic [UB_W-1:0]     rsp_upper_bound_ms,
   output logic [MEAN_W-1:0]   rsp_mean_us,
   output logic [SAMPLE_W-1:0] rsp_sample_count
);

   logic [CNT_W-1:0]    cnt_ff [NUM_BUCKETS];
   logic [SUM_W-1:0]    sum_ff;
   logic [TOT_W-1:0]    total_ff;

   logic [US_W-1:0]     us_ff;
   logic [Q_W-1:0]      q_ff;
   logic [PROD_W-1:0]   prod_ff;
   logic [TOT_W-1:0]    target_ff;
   logic [TOT_W-1:0]    cum_ff;
   logic [BUCKET_W-1:0] walk_ff;

   logic [IDX_W-1:0]    res_idx_ff;
   logic [UB_W-1:0]     res_ub_ff;
   logic [MEAN_W-1:0]   res_mean_ff;

   logic [IDX_W-1:0]    rsp_idx_ff;
   logic [UB_W-1:0]     rsp_ub_ff;
   logic [MEAN_W-1:0]   rsp_mean_ff;
   logic [SAMPLE_W-1:0] rsp_cnt_ff;

   logic [BUCKET_W-1:0] bucket;
   logic [BUCKET_W-1:0] rd_addr;
   logic [CNT_W-1:0]    cnt_rd;
   logic [SUM_W:0]      sum_add;
   logic [Q_W-1:0]      q_clamp;
   logic [PROD_W-1:0]   tgt_sum;
   logic [TOT_W-1:0]    cum_nx;
   logic                div_done;
   logic [SUM_W-1:0]    quotient;
   logic [MEAN_W-1:0]   mean_sat;

   always_comb begin
      bucket   = bucket_of(us_ff);
      rd_addr  = cmd.walk ? walk_ff : bucket;
      cnt_rd   = cnt_ff[rd_addr];
      sum_add  = {1'b0, sum_ff} + (SUM_W + 1)'(us_ff);
      q_clamp  = (q_ff > Q_ONE) ? Q_ONE : q_ff;
      tgt_sum  = prod_ff + PROD_W'(16'hFFFF);
      cum_nx   = cum_ff + TOT_W'(cnt_rd);
      mean_sat = (|quotient[SUM_W-1:MEAN_W]) ? '1 : quotient[MEAN_W-1:0];
   end

   assign stat.total_zero = (total_ff == '0);
   assign stat.walk_hit   = (cum_nx >= target_ff) || (walk_ff == LAST_BUCKET);
   assign stat.div_done   = div_done;

   l2lh_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (sum_ff),
      .divisor  (total_ff),
      .done     (div_done),
      .quotient (quotient)
   );

   // histogram state
   always_ff @(posedge clock) begin
      if (reset || cmd.clear) begin
         for (int i = 0; i < NUM_BUCKETS; i++) begin
            cnt_ff[i] <= '0;
         end
         sum_ff   <= '0;
         total_ff <= '0;
      end else if (cmd.record) begin
         // hold a full counter; the sum still takes the sample
         if (cnt_rd != '1) begin
            cnt_ff[bucket] <= cnt_rd + 1'b1;
            total_ff       <= total_ff + 1'b1;
         end
         sum_ff <= sum_add[SUM_W] ? '1 : sum_add[SUM_W-1:0];
      end
   end

   // request capture, percentile walk and result
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         us_ff       <= req_latency_us;
         q_ff        <= req_quantile_q16;
         res_idx_ff  <= '0;
         res_ub_ff   <= '0;
         res_mean_ff <= '0;
      end
      if (cmd.record) begin
         res_idx_ff <= idx_out(bucket);
      end
      if (cmd.mul) begin
         prod_ff <= PROD_W'(total_ff) * PROD_W'(q_clamp);
      end
      if (cmd.target) begin
         target_ff <= tgt_sum[TOT_W+15:16];
         cum_ff    <= '0;
         walk_ff   <= '0;
      end
      if (cmd.walk) begin
         cum_ff <= cum_nx;
         if (stat.walk_hit) begin
            res_idx_ff <= idx_out(walk_ff);
            res_ub_ff  <= bound_ms(walk_ff);
         end else begin
            walk_ff <= walk_ff + 1'b1;
         end
      end
      if (div_done) begin
         res_mean_ff <= mean_sat;
      end
      if (cmd.load_rsp) begin
         rsp_idx_ff  <= res_idx_ff;
         rsp_ub_ff   <= res_ub_ff;
         rsp_mean_ff <= res_mean_ff;
         rsp_cnt_ff  <= sat_total(total_ff);
      end
   end

   assign rsp_bucket_index   = rsp_idx_ff;
   assign rsp_upper_bound_ms = rsp_ub_ff;
   assign rsp_mean_us        = rsp_mean_ff;
   assign rsp_sample_count   = rsp_cnt_ff;

endmodule

@@ sv/l2lh_ctrl.sv @@
// ----------------------------------------------------------------------------
// l2lh_ctrl
// Sequencer for the histogram: dispatches each request by mode, steps the
// datapath and hands the result to the response register.
// ----------------------------------------------------------------------------
module l2lh_ctrl
   import l2lh_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [1:0] req_mode,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output cmd_type    cmd,
   input  status_type stat
);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_RECORD,
      ST_CLEAR,
      ST_MUL,
      ST_TARGET,
      ST_WALK,
      ST_MEAN,
      ST_DIV_WAIT,
      ST_DONE
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   always_comb begin
      cmd          = '0;
      state_in     = state_ff;
      out_free     = !rsp_valid_ff || !rsp_stall;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               unique case (mode_type'(req_mode))
                  MODE_RECORD: state_in = ST_RECORD;
                  MODE_PCT:    state_in = ST_MUL;
                  MODE_MEAN:   state_in = ST_MEAN;
                  MODE_CLEAR:  state_in = ST_CLEAR;
                  default:     state_in = ST_IDLE;
               endcase
            end
         end
         ST_RECORD: begin
            cmd.record = 1'b1;
            state_in   = ST_DONE;
         end
         ST_CLEAR: begin
            cmd.clear = 1'b1;
            state_in  = ST_DONE;
         end
         ST_MUL: begin
            // empty histogram: the zeroed result stands
            if (stat.total_zero) begin
               state_in = ST_DONE;
            end else begin
               cmd.mul  = 1'b1;
               state_in = ST_TARGET;
            end
         end
         ST_TARGET: begin
            cmd.target = 1'b1;
            state_in   = ST_WALK;
         end
         ST_WALK: begin
            cmd.walk = 1'b1;
            if (stat.walk_hit) begin
               state_in = ST_DONE;
            end
         end
         ST_MEAN: begin
            if (stat.total_zero) begin
               state_in = ST_DONE;
            end else begin
               cmd.div_start = 1'b1;
               state_in      = ST_DIV_WAIT;
            end
         end
         ST_DIV_WAIT: begin
            if (stat.div_done) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            // hold the result until the response register frees up
            if (out_free) begin
               cmd.load_rsp = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule
